// ===== sv/positional_insert_delete_list_macros.svh =====
// Assertion helpers used by the list controller.
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

// same-cycle implication, checked outside reset
`define PIDL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list assertion failed");

// next-cycle implication, checked outside reset
`define PIDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list assertion failed");

`endif

// ===== sv/pidl_pkg.sv =====
package pidl_pkg;

  localparam int OP_W       = 2;
  localparam int VAL_W      = 32;
  localparam int POS_W      = 5;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int DEPTH_DEF  = 16;
  localparam int DUMP_LIMIT = 1 << IDX_W;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic             do_insert;
    logic             do_remove;
    logic             load_out;
    status_t          res_status;
    logic             res_dump;
    logic             res_last;
    logic [IDX_W-1:0] rd_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic ins_bad_pos;
    logic full;
    logic rem_bad;
    logic empty;
    logic dump_last;
  } dp_stat_t;

endpackage

// ===== sv/positional_insert_delete_list.sv =====
// Ordered list of up to DEPTH signed 32-bit entries with insert at a position,
// remove at a position and dump. Insert, remove, an empty dump and an unused
// op each give one result; the whole list shifts at once, in the same update
// that loads that result. A dump gives min(count, 16) results, one per cycle
// while the consumer does not stall, stepping a read index through the entry
// registers; no new transaction is taken until the final result of the dump
// is loaded into the output register. A result waiting in the output register
// does not block the next transaction when the consumer takes it in the same
// cycle. The list is empty after reset, with no clearing pass.
module positional_insert_delete_list
  import pidl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_element,
  output logic [IDX_W-1:0]        out_index,
  output logic [CNT_W-1:0]        out_count,
  output logic                    out_last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pidl_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pidl_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_value    (in_value),
    .in_position (in_position),
    .out_status  (out_status),
    .out_element (out_element),
    .out_index   (out_index),
    .out_count   (out_count),
    .out_last    (out_last)
  );

endmodule

// ===== sv/pidl_datapath.sv =====
module pidl_datapath
  import pidl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_cmd_t                cmd,
  output dp_stat_t                stat,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_element,
  output logic [IDX_W-1:0]        out_index,
  output logic [CNT_W-1:0]        out_count,
  output logic                    out_last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = (CW > POS_W) ? CW : POS_W;

  logic signed [VAL_W-1:0] entries_r [DEPTH];
  logic signed [VAL_W-1:0] ent_nxt   [DEPTH];
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [EW-1:0]           pos_x;
  logic [EW-1:0]           cnt_x;
  logic [EW-1:0]           idx_x;
  logic [AW-1:0]           rd_addr;

  status_t                 status_r;
  logic signed [VAL_W-1:0] element_r;
  logic [IDX_W-1:0]        index_r;
  logic [CNT_W-1:0]        ocount_r;
  logic                    last_r;

  assign pos_x   = EW'(in_position);
  assign cnt_x   = EW'(count_r);
  assign idx_x   = EW'(cmd.rd_idx);
  assign rd_addr = AW'(cmd.rd_idx);

  assign stat.ins_bad_pos = pos_x > cnt_x;
  assign stat.full        = count_r == CW'(DEPTH);
  assign stat.rem_bad     = pos_x >= cnt_x;
  assign stat.empty       = count_r == '0;
  assign stat.dump_last   = (idx_x + EW'(1) == cnt_x) ||
                            (cmd.rd_idx == IDX_W'(DUMP_LIMIT - 1));

  always_comb begin
    count_nxt = count_r;
    if (cmd.do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.do_remove) begin
      count_nxt = count_r - CW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic signed [VAL_W-1:0] below_w;
    logic signed [VAL_W-1:0] above_w;

    if (i > 0) begin : g_below
      assign below_w = entries_r[i-1];
    end else begin : g_no_below
      assign below_w = entries_r[i];
    end

    if (i < DEPTH - 1) begin : g_above
      assign above_w = entries_r[i+1];
    end else begin : g_no_above
      assign above_w = entries_r[i];
    end

    assign ent_nxt[i] =
      (cmd.do_insert && EW'(i) == pos_x)                          ? in_value :
      (cmd.do_insert && EW'(i) > pos_x && EW'(i) <= cnt_x)        ? below_w  :
      (cmd.do_remove && EW'(i) >= pos_x && EW'(i + 1) < cnt_x)    ? above_w  :
                                                                    entries_r[i];
  end

  always_ff @(posedge clk) begin
    entries_r <= ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r  <= cmd.res_status;
      element_r <= cmd.res_dump ? entries_r[rd_addr] : '0;
      index_r   <= cmd.res_dump ? cmd.rd_idx : '0;
      ocount_r  <= CNT_W'(count_nxt);
      last_r    <= cmd.res_last;
    end
  end

  assign out_status  = status_r;
  assign out_element = element_r;
  assign out_index   = index_r;
  assign out_count   = ocount_r;
  assign out_last    = last_r;

endmodule

// ===== sv/pidl_controller.sv =====
`include "positional_insert_delete_list_macros.svh"

module pidl_controller
  import pidl_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [OP_W-1:0] in_op,
  output logic            out_valid,
  input  logic            out_stall,
  input  dp_stat_t        stat,
  output ctl_cmd_t        cmd
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             load_ok;
  logic             accept;
  op_e_t            op;

  assign op       = op_e_t'(in_op);
  assign load_ok  = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == S_IDLE && load_ok);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    cmd.rd_idx     = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_out = 1'b1;
          cmd.res_last = 1'b1;
          unique case (op)
            OP_INSERT: begin
              if (stat.ins_bad_pos) begin
                cmd.res_status = ST_INVALID;
              end else if (stat.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.do_insert = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (stat.rem_bad) begin
                cmd.res_status = ST_INVALID;
              end else begin
                cmd.do_remove = 1'b1;
              end
            end
            OP_DUMP: begin
              if (stat.empty) begin
                cmd.res_status = ST_INVALID;
              end else begin
                cmd.res_dump = 1'b1;
                cmd.res_last = stat.dump_last;
                if (!stat.dump_last) begin
                  state_nxt = S_DUMP;
                  idx_nxt   = idx_r + IDX_W'(1);
                end
              end
            end
            default: begin
              cmd.res_status = ST_INVALID;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (load_ok) begin
          cmd.load_out = 1'b1;
          cmd.res_dump = 1'b1;
          cmd.res_last = stat.dump_last;
          if (stat.dump_last) begin
            state_nxt = S_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PIDL_ASSERT_IMPL(a_no_overwrite, out_valid_r && out_stall, !cmd.load_out)
  `PIDL_ASSERT_NEXT(a_result_held, out_valid_r && out_stall, out_valid_r)
  `PIDL_ASSERT_IMPL(a_one_update, cmd.do_insert || cmd.do_remove,
                    cmd.load_out && !(cmd.do_insert && cmd.do_remove))
  `PIDL_ASSERT_NEXT(a_dump_ends, state_r == S_DUMP && cmd.load_out && cmd.res_last,
                    state_r == S_IDLE && idx_r == '0)

endmodule
